// ===== hdl/dorq_pkg.sv =====
// Package for the drop-oldest ring queue: operation codes, the structs passed
// between the queue modules and the default sizes. Depends on nothing.
package dorq_pkg;

   localparam int DEFAULT_MAX_DEPTH  = 16;
   localparam int DEFAULT_WORD_WIDTH = 32;

   // Capacity register: field width, reset value and the smallest usable ring.
   localparam int CFG_WIDTH   = 5;
   localparam int LIMIT_RESET = 16;
   localparam int LIMIT_MIN   = 2;

   typedef enum logic [1:0] {
      MODE_QUERY       = 2'd0,
      MODE_STORE       = 2'd1,
      MODE_DROP_OLDEST = 2'd2,
      MODE_DROP_NEWEST = 2'd3
   } mode_type;

   // One queue operation presented to the state unit.
   typedef struct packed {
      logic     advance;
      mode_type mode;
   } dorq_op_type;

   // Flags that come back with each operation's result.
   typedef struct packed {
      logic is_empty;
      logic dropped_valid;
   } dorq_status_type;

endpackage

// ===== hdl/dorq_ring_mem.sv =====
// Ring storage of the drop-oldest ring queue: one write port and two read
// ports with registered read data. Depends on nothing.
module dorq_ring_mem #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_WIDTH-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WORD_WIDTH-1:0]    rd_data_a,
   output logic [WORD_WIDTH-1:0]    rd_data_b
);

   logic [WORD_WIDTH-1:0] ring_mem_ff [DEPTH];
   logic [WORD_WIDTH-1:0] rd_a_ff;
   logic [WORD_WIDTH-1:0] rd_b_ff;

   // A read of the address being written returns the new word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= (wr_en && (rd_addr_a == wr_addr)) ? wr_data : ring_mem_ff[rd_addr_a];
      rd_b_ff <= (wr_en && (rd_addr_b == wr_addr)) ? wr_data : ring_mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/dorq_queue_state.sv =====
// Queue state of the drop-oldest ring queue: pointers, count, limit, cached end
// words and the next result values. Depends on dorq_pkg and dorq_ring_mem.
module dorq_queue_state #(
   parameter int MAX_DEPTH  = dorq_pkg::DEFAULT_MAX_DEPTH,
   parameter int WORD_WIDTH = dorq_pkg::DEFAULT_WORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dorq_pkg::dorq_op_type           op,
   input  logic [WORD_WIDTH-1:0]           store_word,
   input  logic                            cfg_write,
   input  logic [$clog2(MAX_DEPTH+1)-1:0]  cfg_limit,
   output logic [$clog2(MAX_DEPTH)-1:0]    entry_count,
   output dorq_pkg::dorq_status_type       status,
   output logic [WORD_WIDTH-1:0]           oldest_word,
   output logic [WORD_WIDTH-1:0]           newest_word,
   output logic [WORD_WIDTH-1:0]           dropped_word
);

   localparam int PTR_W = $clog2(MAX_DEPTH);
   localparam int LIM_W = $clog2(MAX_DEPTH + 1);
   localparam int RESET_LIMIT =
      (dorq_pkg::LIMIT_RESET > MAX_DEPTH) ? MAX_DEPTH : dorq_pkg::LIMIT_RESET;

   logic [LIM_W-1:0]      limit_ff, limit_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [PTR_W-1:0]      count_ff, count_in;
   logic [WORD_WIDTH-1:0] oldest_ff, oldest_in;
   logic [WORD_WIDTH-1:0] newest_ff, newest_in;

   logic                  wr_en;
   logic [PTR_W-1:0]      rd_addr_second;
   logic [PTR_W-1:0]      rd_addr_penult;
   logic [WORD_WIDTH-1:0] second_word;
   logic [WORD_WIDTH-1:0] penult_word;
   logic                  full;
   logic                  empty_now;
   logic                  many;
   logic                  dropped_valid;
   logic                  empty_next;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p,
                                                 input logic [LIM_W-1:0] lim);
      if (LIM_W'(p) == (lim - 1'b1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p,
                                                 input logic [LIM_W-1:0] lim);
      if (p == '0) begin
         return PTR_W'(lim - 1'b1);
      end
      return p - 1'b1;
   endfunction

   always_comb begin
      full      = (LIM_W'(count_ff) == (limit_ff - 1'b1));
      empty_now = (count_ff == '0);
      many      = (count_ff > PTR_W'(1));

      limit_in      = limit_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      oldest_in     = oldest_ff;
      newest_in     = newest_ff;
      wr_en         = 1'b0;
      dropped_valid = 1'b0;
      dropped_word  = '0;

      if (op.advance) begin
         unique case (op.mode)
            dorq_pkg::MODE_QUERY: begin
            end
            dorq_pkg::MODE_STORE: begin
               wr_en     = 1'b1;
               tail_in   = ptr_next(tail_ff, limit_ff);
               newest_in = store_word;
               if (full) begin
                  // The ring wraps onto the head: the oldest entry is evicted.
                  dropped_valid = 1'b1;
                  dropped_word  = oldest_ff;
                  head_in       = ptr_next(head_ff, limit_ff);
                  oldest_in     = many ? second_word : store_word;
               end else begin
                  count_in = count_ff + 1'b1;
                  if (empty_now) begin
                     oldest_in = store_word;
                  end
               end
            end
            dorq_pkg::MODE_DROP_OLDEST: begin
               if (!empty_now) begin
                  dropped_valid = 1'b1;
                  dropped_word  = oldest_ff;
                  head_in       = ptr_next(head_ff, limit_ff);
                  count_in      = count_ff - 1'b1;
                  oldest_in     = second_word;
               end
            end
            dorq_pkg::MODE_DROP_NEWEST: begin
               if (!empty_now) begin
                  dropped_valid = 1'b1;
                  dropped_word  = newest_ff;
                  tail_in       = ptr_prev(tail_ff, limit_ff);
                  count_in      = count_ff - 1'b1;
                  newest_in     = penult_word;
               end
            end
         endcase
      end

      // A new limit empties the queue.
      if (cfg_write) begin
         limit_in = cfg_limit;
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end

      // Fetch the words next to each end for the following operation.
      rd_addr_second = ptr_next(head_in, limit_in);
      rd_addr_penult = ptr_prev(ptr_prev(tail_in, limit_in), limit_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIM_W'(RESET_LIMIT);
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         limit_ff <= limit_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      oldest_ff <= oldest_in;
      newest_ff <= newest_in;
   end

   dorq_ring_mem #(
      .DEPTH      (MAX_DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_ring_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (tail_ff),
      .wr_data   (store_word),
      .rd_addr_a (rd_addr_second),
      .rd_addr_b (rd_addr_penult),
      .rd_data_a (second_word),
      .rd_data_b (penult_word)
   );

   assign empty_next             = (count_in == '0);
   assign entry_count            = count_in;
   assign status.is_empty        = empty_next;
   assign status.dropped_valid   = dropped_valid;
   assign oldest_word            = empty_next ? '0 : oldest_in;
   assign newest_word            = empty_next ? '0 : newest_in;

   a_count_below_limit: assert property (@(posedge clock) disable iff (reset)
      LIM_W'(count_ff) < limit_ff)
      else $error("entry count reached the ring limit");

   a_pointers_in_ring: assert property (@(posedge clock) disable iff (reset)
      (LIM_W'(head_ff) < limit_ff) && (LIM_W'(tail_ff) < limit_ff))
      else $error("head or tail pointer outside the ring in use");

   a_limit_in_range: assert property (@(posedge clock) disable iff (reset)
      (limit_ff >= LIM_W'(dorq_pkg::LIMIT_MIN)) && (limit_ff <= LIM_W'(MAX_DEPTH)))
      else $error("ring limit outside its legal range");

   a_drop_needs_op: assert property (@(posedge clock) disable iff (reset)
      dropped_valid |-> (op.advance && (op.mode != dorq_pkg::MODE_QUERY)))
      else $error("entry dropped without a storing or dropping operation");

   a_cfg_empties: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> ((count_ff == '0) && (head_ff == tail_ff)))
      else $error("limit write did not empty the queue");

endmodule

// ===== hdl/drop_oldest_ring_queue.sv =====
// Drop-oldest ring queue: a ring of data words whose size in use is set by the
// capacity register; it holds at most that size minus one entries, and a store
// into a full queue evicts and reports the oldest entry. Each request transfer
// carries a query, a store, a drop of the oldest or a drop of the newest entry
// and yields exactly one response transfer with the count, the empty flag, the
// oldest and newest words (zero when empty) and any dropped entry. A request
// is taken into an input register, worked against the queue state and placed
// in a response register, so the block takes one request every cycle while the
// response side does not stall. The response is offered once the request has
// passed the input register and the response register. The rate rests on the
// update of the head and tail pointers at each advance and on the two-port ring
// memory, whose registered read ports fetch the words next to each end ahead of
// the next operation. A write to the capacity register
// empties the queue; values below two act as two and values above the ring
// depth act as the depth. The register is taken only while the input register
// is empty, and writes should be made only while no response is outstanding.
// No clearing pass is needed after reset.
// Depends on dorq_pkg and dorq_queue_state.
module drop_oldest_ring_queue #(
   parameter int MAX_DEPTH  = dorq_pkg::DEFAULT_MAX_DEPTH,
   parameter int WORD_WIDTH = dorq_pkg::DEFAULT_WORD_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_mode,
   input  logic [WORD_WIDTH-1:0]          req_store_word,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [$clog2(MAX_DEPTH)-1:0]   rsp_entry_count,
   output logic                           rsp_is_empty,
   output logic [WORD_WIDTH-1:0]          rsp_oldest_word,
   output logic [WORD_WIDTH-1:0]          rsp_newest_word,
   output logic                           rsp_dropped_valid,
   output logic [WORD_WIDTH-1:0]          rsp_dropped_word,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dorq_pkg::CFG_WIDTH-1:0] csr_capacity_limit
);

   localparam int PTR_W = $clog2(MAX_DEPTH);
   localparam int LIM_W = $clog2(MAX_DEPTH + 1);

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   logic [1:0]            in_mode_ff;
   logic [WORD_WIDTH-1:0] in_word_ff;

   // Response register.
   logic                  out_valid_ff, out_valid_in;
   logic [PTR_W-1:0]      out_count_ff;
   logic                  out_empty_ff;
   logic [WORD_WIDTH-1:0] out_oldest_ff;
   logic [WORD_WIDTH-1:0] out_newest_ff;
   logic                  out_dropped_valid_ff;
   logic [WORD_WIDTH-1:0] out_dropped_word_ff;

   logic                        req_take;
   logic                        rsp_take;
   logic                        advance;
   logic                        cfg_write;
   logic [LIM_W-1:0]            cfg_limit;
   dorq_pkg::dorq_op_type       op;
   dorq_pkg::dorq_status_type   status;
   logic [PTR_W-1:0]            next_count;
   logic [WORD_WIDTH-1:0]       next_oldest;
   logic [WORD_WIDTH-1:0]       next_newest;
   logic [WORD_WIDTH-1:0]       next_dropped;

   // The held request moves on when the response register is free or is
   // being emptied by a transfer in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   // The limit register is only written with no request in the input stage,
   // so a write never races a pointer update.
   assign csr_ready = !in_valid_ff;
   assign cfg_write = csr_valid && csr_ready;

   always_comb begin
      if (csr_capacity_limit < dorq_pkg::CFG_WIDTH'(dorq_pkg::LIMIT_MIN)) begin
         cfg_limit = LIM_W'(dorq_pkg::LIMIT_MIN);
      end else if (32'(csr_capacity_limit) > 32'(MAX_DEPTH)) begin
         cfg_limit = LIM_W'(MAX_DEPTH);
      end else begin
         cfg_limit = LIM_W'(csr_capacity_limit);
      end
   end

   always_comb begin
      priority if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      priority if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_mode;
         in_word_ff <= req_store_word;
      end
      if (advance) begin
         out_count_ff         <= next_count;
         out_empty_ff         <= status.is_empty;
         out_oldest_ff        <= next_oldest;
         out_newest_ff        <= next_newest;
         out_dropped_valid_ff <= status.dropped_valid;
         out_dropped_word_ff  <= next_dropped;
      end
   end

   assign op.advance = advance;
   assign op.mode    = dorq_pkg::mode_type'(in_mode_ff);

   dorq_queue_state #(
      .MAX_DEPTH  (MAX_DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_queue_state (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .store_word   (in_word_ff),
      .cfg_write    (cfg_write),
      .cfg_limit    (cfg_limit),
      .entry_count  (next_count),
      .status       (status),
      .oldest_word  (next_oldest),
      .newest_word  (next_newest),
      .dropped_word (next_dropped)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_entry_count   = out_count_ff;
   assign rsp_is_empty      = out_empty_ff;
   assign rsp_oldest_word   = out_oldest_ff;
   assign rsp_newest_word   = out_newest_ff;
   assign rsp_dropped_valid = out_dropped_valid_ff;
   assign rsp_dropped_word  = out_dropped_word_ff;

   // A held request must leave the input stage in the same cycle as a response
   // transfer frees the response register.
   a_advance_after_take: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_stall) |-> advance)
      else $error("held request did not advance into a free response register");

   // Every advance produces a response in the next cycle.
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced request left no response");

   // A response with an empty queue reports zero entries and zero end words.
   a_empty_response: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_empty_ff) |->
         ((out_count_ff == '0) && (out_oldest_ff == '0) && (out_newest_ff == '0)))
      else $error("empty response carries entries or words");

   // A dropped word is reported only together with its flag.
   a_drop_word_gated: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_dropped_valid_ff) |-> (out_dropped_word_ff == '0))
      else $error("dropped word without dropped flag");

endmodule
